>>> sv/fve_pkg.sv
// shared types, codes and instrument rom of the fm voice envelope engine
package fve_pkg;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_KEY_ON  = 3'd1,
        MODE_KEY_OFF = 3'd2,
        MODE_LOAD    = 3'd3,
        MODE_SILENCE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_AMP      = 2'd0,
        KIND_PITCH    = 2'd1,
        KIND_FEEDBACK = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  step;
        logic  last;
        mode_t mode;
    } dp_cmd_t;

    typedef struct packed {
        logic [0:3][7:0] start;
        logic [0:3][7:0] decay;
        logic [0:3][7:0] sustain;
        logic [0:3][7:0] transpose;
        logic [7:0]      feedback;
        logic [7:0]      offset;
    } voice_t;

    localparam int RomDepth = 8;
    localparam logic [7:0] AmpSilent = 8'h80;

    localparam voice_t VOICE_ROM [RomDepth] = '{
        '{'{8'h30,8'h40,8'h40,8'hc0}, '{8'h04,8'h02,8'h10,8'h03},
          '{8'h04,8'h02,8'h10,8'h60}, '{8'd0,8'd0,8'd0,8'd0},     8'd0, 8'h00},
        '{'{8'h6f,8'h40,8'h68,8'hc0}, '{8'h00,8'hff,8'h02,8'h08},
          '{8'h00,8'h00,8'h40,8'h10}, '{8'd12,8'd36,8'd0,8'd24},  8'd8, 8'hf4},
        '{'{8'h58,8'h88,8'h58,8'hc0}, '{8'h18,8'h08,8'h04,8'h03},
          '{8'h18,8'h08,8'h04,8'h04}, '{8'd28,8'd12,8'd0,8'd12},  8'd0, 8'he8},
        '{'{8'h88,8'h8f,8'h8f,8'he0}, '{8'h18,8'h02,8'h04,8'h05},
          '{8'h18,8'h08,8'h08,8'h00}, '{8'd36,8'd0,8'd0,8'd0},    8'd8, 8'hf8},
        '{'{8'h60,8'h40,8'h01,8'h60}, '{8'h00,8'hff,8'hf8,8'hff},
          '{8'h00,8'h60,8'h60,8'h60}, '{8'd12,8'd36,8'd12,8'd24}, 8'd4, 8'he8},
        '{'{8'h00,8'h00,8'h40,8'he0}, '{8'h00,8'h00,8'h04,8'h06},
          '{8'h00,8'h00,8'h00,8'h40}, '{8'd12,8'd36,8'd12,8'd24}, 8'd0, 8'hf4},
        '{'{8'h50,8'h30,8'h50,8'he0}, '{8'h02,8'h03,8'h01,8'h04},
          '{8'h00,8'h00,8'h00,8'h00}, '{8'd0,8'd24,8'd0,8'd19},   8'd2, 8'h00},
        '{'{8'h00,8'h00,8'h00,8'he0}, '{8'h00,8'h00,8'h00,8'h12},
          '{8'h00,8'h00,8'h00,8'h00}, '{8'd0,8'd0,8'd0,8'd0},     8'd0, 8'h00}
    };

    function automatic logic [7:0] amp_code(input logic [7:0] a);
        amp_code = {1'b1, a[7:1]};
    endfunction

endpackage

>>> sv/fve_ctrl.sv
// command sequencer of the fm voice envelope engine
module fve_ctrl #(
    parameter int CHANNELS = 4,
    parameter int OPS      = 16,
    parameter int IW       = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [1:0]            channel,
    input  logic                  out_free,
    input  logic [CHANNELS-1:0]   held_mask,
    output fve_pkg::dp_cmd_t      cmd,
    output logic [IW-1:0]         idx
);
    import fve_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    ctrl_state_t state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    logic [CW-1:0]       tick_ch;
    logic                tick_held;
    logic [CHANNELS-1:0] upper;
    logic                ch_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_TICK;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign idx       = cnt_reg;
    assign tick_ch   = CW'(cnt_reg >> 2);
    assign tick_held = held_mask[tick_ch];
    assign upper     = (held_mask >> tick_ch) >> 1;
    assign ch_ok     = (int'(channel) < CHANNELS);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        in_ready   = (state_reg == ST_IDLE);
        cmd.latch  = 1'b0;
        cmd.step   = 1'b0;
        cmd.last   = 1'b0;
        cmd.mode   = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    mode_next = mode_t'(mode);
                    cnt_next  = '0;
                    unique case (mode_t'(mode))
                        MODE_TICK:    state_next = (held_mask != '0) ? ST_RUN : ST_IDLE;
                        MODE_SILENCE: state_next = ST_RUN;
                        MODE_KEY_ON, MODE_KEY_OFF, MODE_LOAD:
                            state_next = ch_ok ? ST_RUN : ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN:
            begin
                unique case (mode_reg)
                    MODE_TICK:
                    begin
                        // unheld channels are walked past without a transfer
                        if (!tick_held || out_free)
                        begin
                            cmd.step = tick_held;
                            cmd.last = tick_held && (cnt_reg[1:0] == 2'b11)
                                       && (upper == '0);
                            cnt_next = cnt_reg + 1'b1;
                            if (cmd.last || cnt_reg == IW'(OPS - 1))
                                state_next = ST_IDLE;
                        end
                    end
                    MODE_KEY_ON:
                    begin
                        if (out_free)
                        begin
                            cmd.step = 1'b1;
                            cmd.last = (cnt_reg == IW'(7));
                            cnt_next = cnt_reg + 1'b1;
                            if (cmd.last)
                                state_next = ST_IDLE;
                        end
                    end
                    MODE_SILENCE:
                    begin
                        if (out_free)
                        begin
                            cmd.step = 1'b1;
                            cmd.last = (cnt_reg == IW'(OPS - 1));
                            cnt_next = cnt_reg + 1'b1;
                            if (cmd.last)
                                state_next = ST_IDLE;
                        end
                    end
                    MODE_KEY_OFF, MODE_LOAD:
                    begin
                        if (out_free)
                        begin
                            cmd.step   = 1'b1;
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> out_free) else $error("step without free output register");
    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd.step) else $error("step while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("still running after last transfer");
`endif

endmodule

>>> sv/fve_datapath.sv
// operator state, envelope step and output register of the fm voice engine
module fve_datapath #(
    parameter int CHANNELS    = 4,
    parameter int INSTRUMENTS = 8,
    parameter int NOTE_LIMIT  = 107,
    parameter int OPS         = 16,
    parameter int IW          = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fve_pkg::dp_cmd_t      cmd,
    input  logic [IW-1:0]         idx,
    input  logic [1:0]            channel,
    input  logic [7:0]            note,
    input  logic [3:0]            instrument,
    input  logic [7:0]            volume,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            write_kind,
    output logic [3:0]            slot,
    output logic [7:0]            value,
    output logic                  last,
    output logic                  out_free,
    output logic [CHANNELS-1:0]   held_mask
);
    import fve_pkg::*;

    localparam int OPW = $clog2(OPS);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0] start_reg     [OPS];
    logic [7:0] decay_reg     [OPS];
    logic [7:0] sustain_reg   [OPS];
    logic [7:0] transpose_reg [OPS];
    logic [7:0] amp_reg       [OPS];
    logic [7:0] offset_reg    [CHANNELS];
    logic [CHANNELS-1:0] held_reg;

    logic [1:0] ch_reg;
    logic [7:0] note_reg, vol_reg;
    logic [3:0] inst_reg;

    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [3:0] slot_reg;
    logic [7:0] value_reg, res_value;
    logic       last_reg;
    logic [1:0] res_kind;
    logic [3:0] res_slot;

    logic [OPW-1:0] op;
    logic [CW-1:0]  ch_idx;
    logic [7:0]     a, d, s, neg_d, env_next, diff, n_sum, m_sum, pitch;
    logic [8:0]     rise;
    voice_t         voice;
    logic [15:0]    start_prod, sus_prod;
    logic [OPW-1:0] base_op;

    assign ch_idx  = CW'(ch_reg);
    assign base_op = OPW'({ch_reg, 2'b00});

    always_comb
    begin
        unique case (cmd.mode)
            MODE_TICK, MODE_SILENCE: op = OPW'(idx);
            MODE_KEY_OFF:            op = OPW'({ch_reg, 2'b11});
            default:                 op = OPW'({ch_reg, idx[1:0]});
        endcase
    end

    // envelope step toward sustain
    assign a     = amp_reg[op];
    assign d     = decay_reg[op];
    assign s     = sustain_reg[op];
    assign neg_d = 8'(9'd256 - {1'b0, d});
    assign rise  = {1'b0, a} + {1'b0, neg_d};
    assign diff  = a - s;

    always_comb
    begin
        priority if (d[7])
            env_next = (rise[8] || rise[7:0] > s) ? s : rise[7:0];
        else if (a > s)
            env_next = (diff > d) ? (a - d) : s;
        else
            env_next = s;
    end

    assign n_sum = note_reg + offset_reg[ch_idx];
    assign m_sum = transpose_reg[op] + n_sum;
    assign pitch = (m_sum > 8'(NOTE_LIMIT)) ? 8'(NOTE_LIMIT) : m_sum;

    always_comb
    begin
        if (int'(inst_reg) >= INSTRUMENTS)
            voice = VOICE_ROM[0];
        else if (int'(inst_reg) >= RomDepth)
            voice = '0;
        else
            voice = VOICE_ROM[inst_reg[2:0]];
    end

    assign start_prod = voice.start[3] * vol_reg;
    assign sus_prod   = voice.sustain[3] * vol_reg;

    always_comb
    begin
        res_kind  = KIND_AMP;
        res_slot  = 4'(op);
        res_value = AmpSilent;
        unique case (cmd.mode)
            MODE_TICK: res_value = amp_code(env_next);
            MODE_KEY_ON:
            begin
                if (!idx[2])
                begin
                    res_kind  = KIND_PITCH;
                    res_value = pitch;
                end
                else
                    res_value = amp_code(start_reg[op]);
            end
            MODE_LOAD:
            begin
                res_kind  = KIND_FEEDBACK;
                res_slot  = 4'(ch_reg);
                res_value = {voice.feedback[4:0], 3'b000} + 8'h80;
            end
            default: res_value = AmpSilent;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            ch_reg   <= channel;
            note_reg <= note;
            inst_reg <= instrument;
            vol_reg  <= volume;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OPS; i++)
            begin
                start_reg[i]     <= '0;
                decay_reg[i]     <= '0;
                sustain_reg[i]   <= '0;
                transpose_reg[i] <= '0;
                amp_reg[i]       <= '0;
            end
            for (int c = 0; c < CHANNELS; c++)
                offset_reg[c] <= '0;
            held_reg <= '0;
        end
        else if (cmd.step)
        begin
            unique case (cmd.mode)
                MODE_TICK: amp_reg[op] <= env_next;
                MODE_KEY_ON:
                begin
                    if (idx[2])
                        amp_reg[op] <= start_reg[op];
                    if (cmd.last)
                        held_reg[ch_idx] <= 1'b1;
                end
                MODE_KEY_OFF:
                begin
                    amp_reg[op]      <= '0;
                    held_reg[ch_idx] <= 1'b0;
                end
                MODE_LOAD:
                begin
                    offset_reg[ch_idx] <= voice.offset;
                    for (int k = 0; k < 4; k++)
                    begin
                        decay_reg[base_op + OPW'(k)]     <= voice.decay[k];
                        transpose_reg[base_op + OPW'(k)] <= voice.transpose[k];
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        start_reg[base_op + OPW'(k)]   <= voice.start[k];
                        sustain_reg[base_op + OPW'(k)] <= voice.sustain[k];
                    end
                    // carrier levels scaled by volume/128
                    start_reg[base_op + OPW'(3)]   <= start_prod[14:7];
                    sustain_reg[base_op + OPW'(3)] <= sus_prod[14:7];
                end
                MODE_SILENCE:
                begin
                    amp_reg[op] <= '0;
                    if (cmd.last)
                        held_reg <= '0;
                end
                default: held_reg <= held_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            kind_reg  <= res_kind;
            slot_reg  <= res_slot;
            value_reg <= res_value;
            last_reg  <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign write_kind = kind_reg;
    assign slot       = slot_reg;
    assign value      = value_reg;
    assign last       = last_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign held_mask  = held_reg;

endmodule

>>> sv/fm_voice_envelope_engine.sv
// fm voice envelope engine: one command in, its register writes out one per cycle while
// the output is not stalled; the input transfer starts the sequencer and each step loads
// the registered output; key_on, key_off, load and silence_all step through their writes,
// tick walks operators in order up to the last held one and passes unheld channels by;
// commands with no result go straight back to idle, where alone a new command is taken;
// output stalls hold the sequencer; reset clears all operator state and the held mask
module fm_voice_envelope_engine #(
    parameter int CHANNELS    = 4,
    parameter int INSTRUMENTS = 8,
    parameter int NOTE_LIMIT  = 107
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [1:0] channel,
    input  logic [7:0] note,
    input  logic [3:0] instrument,
    input  logic [7:0] volume,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] write_kind,
    output logic [3:0] slot,
    output logic [7:0] value,
    output logic       last
);
    import fve_pkg::*;

    localparam int OPS = CHANNELS * 4;
    localparam int OPW = $clog2(OPS);
    localparam int IW  = (OPW > 3) ? OPW : 3;

    dp_cmd_t             cmd;
    logic [IW-1:0]       idx;
    logic                out_free;
    logic [CHANNELS-1:0] held_mask;

    fve_ctrl #(
        .CHANNELS (CHANNELS),
        .OPS      (OPS),
        .IW       (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .channel   (channel),
        .out_free  (out_free),
        .held_mask (held_mask),
        .cmd       (cmd),
        .idx       (idx)
    );

    fve_datapath #(
        .CHANNELS    (CHANNELS),
        .INSTRUMENTS (INSTRUMENTS),
        .NOTE_LIMIT  (NOTE_LIMIT),
        .OPS         (OPS),
        .IW          (IW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .idx        (idx),
        .channel    (channel),
        .note       (note),
        .instrument (instrument),
        .volume     (volume),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .write_kind (write_kind),
        .slot       (slot),
        .value      (value),
        .last       (last),
        .out_free   (out_free),
        .held_mask  (held_mask)
    );

endmodule

>>> tb/fm_voice_envelope_engine_test.sv
// self-checking testbench of the fm voice envelope engine
`timescale 1ns / 1ps

module fm_voice_envelope_engine_test;
    import fve_pkg::*;

    localparam int NumCh = 4;
    localparam int NumOps = 16;
    localparam int NumInst = 8;
    localparam int NoteCap = 107;
    localparam int StallLimit = 20000;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] slot;
        logic [7:0] value;
        logic       last;
    } write_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] mode;
    logic [1:0] channel;
    logic [7:0] note;
    logic [3:0] instrument;
    logic [7:0] volume;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] write_kind;
    logic [3:0] slot;
    logic [7:0] value;
    logic       last;

    // predictor state
    logic [7:0] start_lvl [NumOps];
    logic [7:0] decay_rt [NumOps];
    logic [7:0] sustain_lvl [NumOps];
    logic [7:0] transp [NumOps];
    logic [7:0] amp [NumOps];
    logic [7:0] ch_offset [NumCh];
    logic [3:0] held;

    write_t pending_writes [$];
    int     fail_count;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    fm_voice_envelope_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .channel(channel), .note(note),
        .instrument(instrument), .volume(volume),
        .out_valid(out_valid), .out_ready(out_ready),
        .write_kind(write_kind), .slot(slot), .value(value), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] level_code(input logic [7:0] a);
        return 8'd128 + {1'b0, a[7:1]};
    endfunction

    function automatic logic [7:0] env_step(input int op);
        logic [7:0] a;
        logic [7:0] d;
        logic [7:0] s;
        logic [8:0] sum;
        a = amp[op];
        d = decay_rt[op];
        s = sustain_lvl[op];
        if (d[7])
        begin
            sum = {1'b0, a} + {1'b0, 8'(9'd256 - d)};
            a = (sum[8] || sum[7:0] > s) ? s : sum[7:0];
        end
        else if (a > s)
            a = (8'(a - s) > d) ? 8'(a - d) : s;
        else
            a = s;
        amp[op] = a;
        return a;
    endfunction

    task automatic queue_write(input logic [1:0] k, input int sl, input logic [7:0] v);
        write_t w;
        w.kind = k;
        w.slot = 4'(sl);
        w.value = v;
        w.last = 1'b0;
        pending_writes.push_back(w);
    endtask

    task automatic predict_writes(input logic [2:0] md, input logic [1:0] ch,
                                  input logic [7:0] nt, input logic [3:0] ins,
                                  input logic [7:0] vol);
        int     before_cnt;
        int     base;
        int     idx;
        logic [7:0] n;
        logic [7:0] m;
        logic [15:0] prod;
        before_cnt = pending_writes.size();
        base = int'(ch) * 4;
        case (md)
            MODE_TICK:
                for (int c = 0; c < NumCh; c++)
                    if (held[c])
                        for (int i = 0; i < 4; i++)
                            queue_write(KIND_AMP, c * 4 + i, level_code(env_step(c * 4 + i)));
            MODE_KEY_ON:
            begin
                n = nt + ch_offset[ch];
                for (int i = 0; i < 4; i++)
                begin
                    m = transp[base + i] + n;
                    if (m > 8'(NoteCap))
                        m = 8'(NoteCap);
                    queue_write(KIND_PITCH, base + i, m);
                end
                for (int i = 0; i < 4; i++)
                begin
                    amp[base + i] = start_lvl[base + i];
                    queue_write(KIND_AMP, base + i, level_code(amp[base + i]));
                end
                held[ch] = 1'b1;
            end
            MODE_KEY_OFF:
            begin
                amp[base + 3] = 8'd0;
                queue_write(KIND_AMP, base + 3, AmpSilent);
                held[ch] = 1'b0;
            end
            MODE_LOAD:
            begin
                idx = (ins >= NumInst) ? 0 : int'(ins);
                ch_offset[ch] = VOICE_ROM[idx].offset;
                for (int i = 0; i < 4; i++)
                begin
                    start_lvl[base + i] = VOICE_ROM[idx].start[i];
                    decay_rt[base + i] = VOICE_ROM[idx].decay[i];
                    sustain_lvl[base + i] = VOICE_ROM[idx].sustain[i];
                    transp[base + i] = VOICE_ROM[idx].transpose[i];
                end
                prod = start_lvl[base + 3] * vol;
                start_lvl[base + 3] = prod[14:7];
                prod = sustain_lvl[base + 3] * vol;
                sustain_lvl[base + 3] = prod[14:7];
                queue_write(KIND_FEEDBACK, base / 4,
                            8'(VOICE_ROM[idx].feedback << 3) + 8'd128);
            end
            MODE_SILENCE:
            begin
                for (int i = 0; i < NumOps; i++)
                begin
                    amp[i] = 8'd0;
                    queue_write(KIND_AMP, i, AmpSilent);
                end
                held = 4'd0;
            end
            default: ;
        endcase
        if (pending_writes.size() > before_cnt)
            pending_writes[$].last = 1'b1;
    endtask

    task automatic send_command(input logic [2:0] md, input logic [1:0] ch,
                                input logic [7:0] nt, input logic [3:0] ins,
                                input logic [7:0] vol);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        mode <= md;
        channel <= ch;
        note <= nt;
        instrument <= ins;
        volume <= vol;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_writes(md, ch, nt, ins, vol);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // check every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        write_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write kind=%0d slot=%0d value=%0d",
                       write_kind, slot, value);
                fail_count++;
            end
            else
            begin
                w = pending_writes.pop_front();
                if (write_kind !== w.kind)
                begin
                    $error("write_kind: expected %0d, got %0d", w.kind, write_kind);
                    fail_count++;
                end
                if (slot !== w.slot)
                begin
                    $error("slot: expected %0d, got %0d", w.slot, slot);
                    fail_count++;
                end
                if (value !== w.value)
                begin
                    $error("value: expected %0d, got %0d", w.value, value);
                    fail_count++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_random_command();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_command(MODE_TICK, 2'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        else if (pick < 55)
            send_command(MODE_KEY_ON, 2'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom));
        else if (pick < 68)
            send_command(MODE_KEY_OFF, 2'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom));
        else if (pick < 90)
            send_command(MODE_LOAD, 2'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        else if (pick < 94)
            send_command(MODE_SILENCE, 2'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom));
        else
            send_command(3'($urandom_range(5, 7)), 2'($urandom), 8'($urandom),
                         4'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        send_command(MODE_TICK, 2'd0, 8'd0, 4'd0, 8'd0);
        send_command(MODE_KEY_ON, 2'd0, 8'd0, 4'd0, 8'd0);
        for (int i = 0; i < NumInst; i++)
            send_command(MODE_LOAD, 2'(i), 8'd0, 4'(i), (i == 0) ? 8'd255 : 8'd128);
        send_command(MODE_LOAD, 2'd3, 8'd255, 4'd15, 8'd0);
        send_command(MODE_LOAD, 2'd2, 8'd0, 4'd8, 8'd1);
        send_command(MODE_KEY_ON, 2'd0, 8'd255, 4'd0, 8'd0);
        send_command(MODE_KEY_ON, 2'd1, 8'd100, 4'd0, 8'd0);
        send_command(MODE_KEY_ON, 2'd2, 8'd12, 4'd0, 8'd0);
        send_command(MODE_KEY_ON, 2'd3, 8'd60, 4'd0, 8'd0);
        send_command(MODE_TICK, 2'd0, 8'd0, 4'd0, 8'd0);
        send_command(MODE_KEY_OFF, 2'd1, 8'd0, 4'd0, 8'd0);
        send_command(MODE_TICK, 2'd0, 8'd0, 4'd0, 8'd0);
        send_command(3'd5, 2'd0, 8'd0, 4'd0, 8'd0);
        send_command(3'd7, 2'd3, 8'd255, 4'd15, 8'd255);
        send_command(MODE_SILENCE, 2'd0, 8'd0, 4'd0, 8'd0);
        send_command(MODE_TICK, 2'd0, 8'd0, 4'd0, 8'd0);
    endtask

    // instruments loaded, notes keyed, then a run of ticks so envelopes settle
    task automatic test_envelopes(input int n);
        for (int c = 0; c < NumCh; c++)
        begin
            send_command(MODE_LOAD, 2'(c), 8'($urandom), 4'($urandom), 8'($urandom));
            send_command(MODE_KEY_ON, 2'(c), 8'($urandom), 4'($urandom), 8'($urandom));
        end
        for (int i = 0; i < n; i++)
            send_command(MODE_TICK, 2'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic test_random(input int n, input int snd, input int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++)
            send_random_command();
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        channel = '0;
        note = '0;
        instrument = '0;
        volume = '0;
        for (int i = 0; i < NumOps; i++)
        begin
            start_lvl[i] = '0;
            decay_rt[i] = '0;
            sustain_lvl[i] = '0;
            transp[i] = '0;
            amp[i] = '0;
        end
        for (int c = 0; c < NumCh; c++)
            ch_offset[c] = '0;
        held = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_envelopes(30);
        test_random(90, 0, 0);
        test_random(90, 80, 0);
        test_random(90, 0, 80);
        test_random(90, 12, 12);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
sv/fve_pkg.sv
sv/fve_ctrl.sv
sv/fve_datapath.sv
sv/fm_voice_envelope_engine.sv
tb/fm_voice_envelope_engine_test.sv
